// File: design/mandelbrot_escape_time_macros.svh
// Assertion macros shared by the escape-time block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication
`define MET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/met_pkg.sv
// Types, constants and helpers of the escape-time block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package met_pkg;

  localparam int ScreenMax  = 4096;
  localparam int FracBits   = 28;
  localparam int CountBits  = 16;
  localparam int QueueDepth = 2;

  localparam int WordW  = 32;
  localparam int ProdW  = 2 * WordW;
  localparam int SqW    = ProdW - FracBits;
  localparam int SatW   = 66;
  localparam int StepW  = 31;
  localparam int OffW   = 12 + StepW;
  localparam int IdxW   = 24;
  localparam int ScrW   = 13;

  typedef enum logic [2:0] {
    RegScreenWidth  = 3'd0,
    RegScreenHeight = 3'd1,
    RegXOrigin      = 3'd2,
    RegYOrigin      = 3'd3,
    RegXStep        = 3'd4,
    RegYStep        = 3'd5,
    RegMaxIter      = 3'd6
  } met_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StAdd,
    StDone
  } met_state_e;

  typedef struct packed {
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
  } met_in_t;

  typedef struct packed {
    logic [CountBits-1:0] iteration_count;
    logic [IdxW-1:0]      pixel_index;
    logic                 in_range;
  } met_out_t;

  typedef struct packed {
    logic [ScrW-1:0]         screen_width;
    logic [ScrW-1:0]         screen_height;
    logic signed [WordW-1:0] x_origin;
    logic signed [WordW-1:0] y_origin;
    logic [StepW-1:0]        x_step;
    logic [StepW-1:0]        y_step;
    logic [CountBits-1:0]    max_iterations;
  } met_cfg_t;

  typedef struct packed {
    logic signed [WordW-1:0] cr;
    logic signed [WordW-1:0] ci;
    logic [IdxW-1:0]         pixel_index;
    logic                    in_range;
  } met_job_t;

  localparam met_cfg_t CfgReset = '{
    screen_width:   ScrW'(1024),
    screen_height:  ScrW'(768),
    x_origin:       -32'sd536870912,
    y_origin:       -32'sd268435456,
    x_step:         StepW'(786432),
    y_step:         StepW'(699051),
    max_iterations: CountBits'(256)
  };

  // clip a wide signed value to the signed word range
  function automatic logic signed [WordW-1:0] sat_word(input logic signed [SatW-1:0] v);
    logic signed [WordW-1:0] r;
    if ((&v[SatW-1:WordW-1]) || !(|v[SatW-1:WordW-1])) begin
      r = v[WordW-1:0];
    end else if (v[SatW-1]) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: design/met_front.sv
// Front end: accepts pixel requests, checks range, maps them to points c.
// Two registered stages (request, then products; sums are combinational); uses met_pkg.
`timescale 1ns / 1ps

module met_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  met_pkg::met_cfg_t cfg_i,
  input  logic              push_i,
  input  met_pkg::met_in_t  item_i,
  output logic              full_o,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output met_pkg::met_job_t job_o
);

  localparam int ExtO = met_pkg::SatW - met_pkg::WordW;
  localparam int ExtP = met_pkg::SatW - met_pkg::OffW;

  logic                          s1_v_q, s1_v_d;
  met_pkg::met_in_t              s1_q;
  logic                          s2_v_q, s2_v_d;
  logic [met_pkg::OffW-1:0]      s2_xp_q, s2_yp_q;
  logic [met_pkg::IdxW-1:0]      s2_idx_q;
  logic                          s2_inr_q;

  logic                          s2_free, s1_adv, s1_load;
  logic                          inr;
  logic [25:0]                   idx_full;
  logic [met_pkg::OffW-1:0]      xp, yp;
  logic [met_pkg::SatW-1:0]      xs, ys;

  assign s2_free = !s2_v_q || job_ready_i;
  assign s1_adv  = s1_v_q && s2_free;
  assign full_o  = s1_v_q && !s2_free;
  assign s1_load = push_i && !full_o;

  assign s1_v_d = s1_load || (s1_v_q && !s1_adv);
  assign s2_v_d = s1_adv || (s2_v_q && !job_ready_i);

  assign inr = ({1'b0, s1_q.pixel_column} < cfg_i.screen_width) &&
               ({1'b0, s1_q.pixel_row} < cfg_i.screen_height);
  assign idx_full = 26'(s1_q.pixel_row) * 26'(cfg_i.screen_width) + 26'(s1_q.pixel_column);
  assign xp = met_pkg::OffW'(s1_q.pixel_column) * met_pkg::OffW'(cfg_i.x_step);
  assign yp = met_pkg::OffW'(s1_q.pixel_row) * met_pkg::OffW'(cfg_i.y_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // hold payload unless the stage advances
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      s2_xp_q  <= xp;
      s2_yp_q  <= yp;
      s2_inr_q <= inr;
      s2_idx_q <= inr ? idx_full[met_pkg::IdxW-1:0] : '0;
    end
  end

  assign xs = {{ExtO{cfg_i.x_origin[met_pkg::WordW-1]}}, cfg_i.x_origin} +
              {{ExtP{1'b0}}, s2_xp_q};
  assign ys = {{ExtO{cfg_i.y_origin[met_pkg::WordW-1]}}, cfg_i.y_origin} +
              {{ExtP{1'b0}}, s2_yp_q};

  assign job_valid_o       = s2_v_q;
  assign job_o.cr          = met_pkg::sat_word($signed(xs));
  assign job_o.ci          = met_pkg::sat_word($signed(ys));
  assign job_o.pixel_index = s2_idx_q;
  assign job_o.in_range    = s2_inr_q;

endmodule

// File: design/met_queue.sv
// Short queue of mapped points between front and back end.
// Register based; uses met_pkg and the block's assertion macros.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module met_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  met_pkg::met_job_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output met_pkg::met_job_t rd_data_o
);

  localparam int PtrW = (met_pkg::QueueDepth > 1) ? $clog2(met_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(met_pkg::QueueDepth + 1);

  met_pkg::met_job_t     mem_q [met_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign wr_ready_o = cnt_q != CntW'(met_pkg::QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(met_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(met_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `MET_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(met_pkg::QueueDepth), "queue overfilled")
  `MET_ASSERT_NOW(a_ptr_gap, cnt_q == '0, wr_ptr_q == rd_ptr_q, "queue pointers out of step")

endmodule

// File: design/met_back.sv
// Back end: runs the escape loop for one point at a time, each iteration a square
// step followed by an add-and-test step, and holds the result register.
// Uses met_pkg and the block's assertion macros.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module met_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [met_pkg::CountBits-1:0] limit_i,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  met_pkg::met_job_t             job_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output met_pkg::met_out_t             item_o
);

  localparam int ExtS = met_pkg::SatW - met_pkg::SqW;
  localparam int ExtW = met_pkg::SatW - met_pkg::WordW;
  localparam int ExtX = met_pkg::SatW - met_pkg::ProdW;
  localparam logic [met_pkg::SqW:0] Four = (met_pkg::SqW + 1)'(4) << met_pkg::FracBits;

  met_pkg::met_state_e            state_q, state_d;
  logic signed [met_pkg::WordW-1:0] zr_q, zr_d, zi_q, zi_d;
  met_pkg::met_job_t              job_q, job_d;
  logic [met_pkg::CountBits-1:0]  cnt_q, cnt_d;
  logic [met_pkg::ProdW-1:0]      rr_p_q, rr_p_d, ii_p_q, ii_p_d;
  logic signed [met_pkg::ProdW-1:0] cr_p_q, cr_p_d;
  logic                           out_v_q, out_v_d;
  met_pkg::met_out_t              out_q, out_d;

  logic [met_pkg::WordW-1:0]      ar, ai;
  logic [met_pkg::SqW-1:0]        rr, ii;
  logic [met_pkg::SqW:0]          sq_sum;
  logic signed [met_pkg::ProdW-1:0] cross_sh;
  logic [met_pkg::SatW-1:0]       zr_sum, zi_sum;
  logic                           pop_ok;

  assign ar = zr_q[met_pkg::WordW-1] ? met_pkg::WordW'(-zr_q) : zr_q;
  assign ai = zi_q[met_pkg::WordW-1] ? met_pkg::WordW'(-zi_q) : zi_q;
  assign rr = rr_p_q[met_pkg::ProdW-1:met_pkg::FracBits];
  assign ii = ii_p_q[met_pkg::ProdW-1:met_pkg::FracBits];
  assign sq_sum = {1'b0, rr} + {1'b0, ii};
  assign cross_sh = cr_p_q >>> (met_pkg::FracBits - 1);
  assign zr_sum = {{ExtS{1'b0}}, rr} - {{ExtS{1'b0}}, ii} +
                  {{ExtW{job_q.cr[met_pkg::WordW-1]}}, job_q.cr};
  assign zi_sum = {{ExtX{cross_sh[met_pkg::ProdW-1]}}, cross_sh} +
                  {{ExtW{job_q.ci[met_pkg::WordW-1]}}, job_q.ci};

  assign pop_ok      = pop_i && out_v_q;
  assign empty_o     = !out_v_q;
  assign item_o      = out_q;
  assign job_ready_o = state_q == met_pkg::StIdle;

  always_comb begin
    state_d = state_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    job_d   = job_q;
    cnt_d   = cnt_q;
    rr_p_d  = rr_p_q;
    ii_p_d  = ii_p_q;
    cr_p_d  = cr_p_q;
    out_v_d = out_v_q && !pop_ok;
    out_d   = out_q;
    unique case (state_q)
      met_pkg::StIdle: begin
        if (job_valid_i) begin
          job_d   = job_i;
          zr_d    = '0;
          zi_d    = '0;
          cnt_d   = '0;
          state_d = job_i.in_range ? met_pkg::StMul : met_pkg::StDone;
        end
      end
      met_pkg::StMul: begin
        if (cnt_q >= limit_i) begin
          state_d = met_pkg::StDone;
        end else begin
          rr_p_d  = met_pkg::ProdW'(ar) * met_pkg::ProdW'(ar);
          ii_p_d  = met_pkg::ProdW'(ai) * met_pkg::ProdW'(ai);
          cr_p_d  = met_pkg::ProdW'(zr_q) * met_pkg::ProdW'(zi_q);
          state_d = met_pkg::StAdd;
        end
      end
      met_pkg::StAdd: begin
        if (sq_sum >= Four) begin
          state_d = met_pkg::StDone;
        end else begin
          zr_d    = met_pkg::sat_word($signed(zr_sum));
          zi_d    = met_pkg::sat_word($signed(zi_sum));
          cnt_d   = cnt_q + 1'b1;
          state_d = met_pkg::StMul;
        end
      end
      met_pkg::StDone: begin
        // advance once the result register is free
        if (!out_v_q || pop_ok) begin
          out_v_d               = 1'b1;
          out_d.iteration_count = cnt_q;
          out_d.pixel_index     = job_q.pixel_index;
          out_d.in_range        = job_q.in_range;
          state_d               = met_pkg::StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= met_pkg::StIdle;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    job_q  <= job_d;
    cnt_q  <= cnt_d;
    rr_p_q <= rr_p_d;
    ii_p_q <= ii_p_d;
    cr_p_q <= cr_p_d;
    out_q  <= out_d;
  end

  `MET_ASSERT_NOW(a_out_of_range, out_v_q && !out_q.in_range, (out_q.iteration_count == '0) && (out_q.pixel_index == '0), "out-of-range result not cleared")
  `MET_ASSERT_NEXT(a_add_step, state_q == met_pkg::StAdd, (state_q == met_pkg::StMul) || (state_q == met_pkg::StDone), "bad step after add")
  `MET_ASSERT_NEXT(a_cnt_step, (state_q == met_pkg::StAdd) && (state_d == met_pkg::StMul), cnt_q == $past(cnt_q) + 1'b1, "count did not advance")

endmodule

// File: design/mandelbrot_escape_time.sv
// Top level of the escape-time block: configuration registers, front end,
// point queue and iteration back end. Uses met_pkg, met_front, met_queue, met_back.
//
//   channel   direction  handshake               payload
//   pixel     in         push / full             in_item_i  (met_in_t)
//   result    out        pop / empty             out_item_o (met_out_t)
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A pixel passes the front-end registers and the queue before the back end loads it;
// the back end then runs the loop until the limit ends it or the point escapes; the single
// squaring loop sets the pace per pixel.
// Pixels outside the screen skip the loop in the back end; a waiting result holds it.
// Reset loads the default view and empties all stages; no clearing pass.
// The front end keeps accepting while the back end iterates, until the queue and the front-end stages fill.
`timescale 1ns / 1ps

module mandelbrot_escape_time (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  met_pkg::met_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output met_pkg::met_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  met_pkg::met_cfg_t       cfg_q, cfg_d;
  logic [met_pkg::ScrW-1:0] scr_val;
  logic                    job_valid, job_ready, deq_valid, deq_ready;
  met_pkg::met_job_t       job, deq_job;

  assign cfg_ready_o = 1'b1;

  // clamp screen sizes, taken from the low ScrW data bits, to the largest supported screen
  assign scr_val = (cfg_data_i[met_pkg::ScrW-1:0] > met_pkg::ScrW'(met_pkg::ScreenMax)) ?
                   met_pkg::ScrW'(met_pkg::ScreenMax) : cfg_data_i[met_pkg::ScrW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (met_pkg::met_reg_e'(cfg_index_i))
        met_pkg::RegScreenWidth:  cfg_d.screen_width   = scr_val;
        met_pkg::RegScreenHeight: cfg_d.screen_height  = scr_val;
        met_pkg::RegXOrigin:      cfg_d.x_origin       = $signed(cfg_data_i);
        met_pkg::RegYOrigin:      cfg_d.y_origin       = $signed(cfg_data_i);
        met_pkg::RegXStep:        cfg_d.x_step         = cfg_data_i[met_pkg::StepW-1:0];
        met_pkg::RegYStep:        cfg_d.y_step         = cfg_data_i[met_pkg::StepW-1:0];
        met_pkg::RegMaxIter:      cfg_d.max_iterations = cfg_data_i[met_pkg::CountBits-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= met_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  met_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  met_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_valid),
    .wr_ready_o (job_ready),
    .wr_data_i  (job),
    .rd_valid_o (deq_valid),
    .rd_ready_i (deq_ready),
    .rd_data_o  (deq_job)
  );

  met_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (cfg_q.max_iterations),
    .job_valid_i (deq_valid),
    .job_ready_o (deq_ready),
    .job_i       (deq_job),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule
